// ----- rtl/core/rational_arithmetic_unit_core_macros.svh -----
// Assertion macros for the rational arithmetic unit core.
// No dependencies; included by the modules that carry checks.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rau assertion failed");
// next-cycle implication
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rau assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/rau_pkg.sv -----
// Shared constants, codes and handshake types for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int OP_WIDTH          = 2;
   localparam int NUM_WIDTH         = 33;
   localparam int DEN_WIDTH         = 31;
   localparam int SIGN_WIDTH        = 2;
   localparam int EXT_WIDTH         = 64;

   localparam logic [OP_WIDTH-1:0] OP_ADD = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV = 2'd3;

   localparam logic [SIGN_WIDTH-1:0] SIGN_NEG  = 2'd0;
   localparam logic [SIGN_WIDTH-1:0] SIGN_ZERO = 2'd1;
   localparam logic [SIGN_WIDTH-1:0] SIGN_POS  = 2'd2;

   typedef struct packed {
      logic go;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

// ----- rtl/core/rau_gcd.sv -----
// Binary GCD unit: one subtract/compare or shift per cycle.
// Depends on rau_pkg.
module rau_gcd #(
   parameter int MAG_WIDTH = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rau_pkg::unit_ctl_type  ctl,
   input  logic [MAG_WIDTH-1:0]   op_a,
   input  logic [MAG_WIDTH-1:0]   op_b,
   output logic [MAG_WIDTH-1:0]   gcd,
   output rau_pkg::unit_sts_type  sts
);

   localparam int KW = $clog2(MAG_WIDTH + 1);

   localparam logic [1:0] G_IDLE    = 2'd0;
   localparam logic [1:0] G_STRIP   = 2'd1;
   localparam logic [1:0] G_REDUCE  = 2'd2;
   localparam logic [1:0] G_RESTORE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [MAG_WIDTH-1:0] u_ff, u_in;
   logic [MAG_WIDTH-1:0] v_ff, v_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [MAG_WIDTH:0]   diff;

   assign diff = {1'b0, u_ff} - {1'b0, v_ff};

   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      case (state_ff)
         G_IDLE: begin
            if (ctl.go) begin
               u_in     = op_a;
               v_in     = op_b;
               k_in     = '0;
               state_in = G_STRIP;
            end
         end
         G_STRIP: begin
            // pull common factors of two out first
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else begin
               state_in = G_REDUCE;
            end
         end
         G_REDUCE: begin
            if (u_ff == '0) begin
               u_in     = v_ff;
               state_in = G_RESTORE;
            end else if (v_ff == '0) begin
               state_in = G_RESTORE;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!diff[MAG_WIDTH]) begin
               u_in = {1'b0, diff[MAG_WIDTH-1:1]};
            end else begin
               // u < v: swap so the next step subtracts the smaller one
               u_in = v_ff;
               v_in = u_ff;
            end
         end
         G_RESTORE: begin
            if (k_ff == '0) begin
               state_in = G_IDLE;
            end else begin
               u_in = u_ff << 1;
               k_in = k_ff - KW'(1);
            end
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
      end else begin
         state_ff <= state_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
   end

   assign gcd      = u_ff;
   assign sts.busy = (state_ff != G_IDLE);
   assign sts.done = (state_ff == G_RESTORE) && (k_ff == '0);

endmodule

// ----- rtl/core/rau_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div #(
   parameter int MAG_WIDTH = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rau_pkg::unit_ctl_type  ctl,
   input  logic [MAG_WIDTH-1:0]   dividend,
   input  logic [MAG_WIDTH-1:0]   divisor,
   output logic [MAG_WIDTH-1:0]   quotient,
   output rau_pkg::unit_sts_type  sts
);

   localparam int CW = $clog2(MAG_WIDTH);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [MAG_WIDTH-1:0] rem_ff, rem_in;
   logic [MAG_WIDTH-1:0] quo_ff, quo_in;
   logic [MAG_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [MAG_WIDTH:0]   rem_sh;
   logic [MAG_WIDTH+1:0] trial;
   logic                 last;

   assign rem_sh = {rem_ff, quo_ff[MAG_WIDTH-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign last   = (cnt_ff == CW'(MAG_WIDTH - 1));

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      if (active_ff) begin
         if (!trial[MAG_WIDTH+1]) begin
            rem_in = trial[MAG_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[MAG_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (last) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end else if (ctl.go) begin
         active_in = 1'b1;
         rem_in    = '0;
         quo_in    = dividend;
         dsr_in    = divisor;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign sts.busy = active_ff;
   assign sts.done = done_ff;

endmodule

// ----- rtl/core/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit: cross multiply, GCD reduce, sign normalize.
// Depends on rau_pkg, rau_gcd, rau_div and rational_arithmetic_unit_core_macros.svh.
// A zero denominator or zero divisor goes from accept straight to the result state, and a
// zero result skips the GCD and both divides. One item at a time: start is taken only in
// idle, after the previous result has been shown; there are no stalls.
// Synchronous active-high reset returns the sequencer to idle; no result is pending.
`include "rational_arithmetic_unit_core_macros.svh"

module rational_arithmetic_unit_core #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rau_pkg::OP_WIDTH-1:0]         req_op,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_den,
   output logic                                 rsp_valid,
   output logic signed [rau_pkg::NUM_WIDTH-1:0] rsp_res_num,
   output logic [rau_pkg::DEN_WIDTH-1:0]        rsp_res_den,
   output logic [rau_pkg::SIGN_WIDTH-1:0]       rsp_res_sign,
   output logic                                 rsp_err
);

   localparam int PW = 2 * OPERAND_WIDTH;     // product width
   localparam int SW = PW + 1;                // signed numerator width
   localparam int MW = PW;                    // magnitude width
   localparam int EW = rau_pkg::EXT_WIDTH;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MA   = 4'd1;
   localparam logic [3:0] S_MB   = 4'd2;
   localparam logic [3:0] S_MC   = 4'd3;
   localparam logic [3:0] S_MD   = 4'd4;
   localparam logic [3:0] S_CHK  = 4'd5;
   localparam logic [3:0] S_GCD  = 4'd6;
   localparam logic [3:0] S_DIVN = 4'd7;
   localparam logic [3:0] S_DIVD = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0]                    state_ff, state_in;
   logic [rau_pkg::OP_WIDTH-1:0]  op_ff, op_in;
   logic signed [OPERAND_WIDTH-1:0] an_ff, an_in, ad_ff, ad_in;
   logic signed [OPERAND_WIDTH-1:0] bn_ff, bn_in, bd_ff, bd_in;
   logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [SW-1:0]          num_ff, num_in;
   logic signed [PW-1:0]          den_ff, den_in;
   logic signed [SW-1:0]          num_abs;
   logic signed [PW-1:0]          den_abs;
   logic [MW-1:0]                 un_ff, un_in, ud_ff, ud_in;
   logic [MW-1:0]                 g_ff, g_in, qn_ff, qn_in;
   logic                          neg_ff, neg_in;
   logic [SW-1:0]                 qn_ext;
   logic signed [SW-1:0]          num_sv;
   logic [EW-1:0]                 num_wide, den_wide;

   logic signed [rau_pkg::NUM_WIDTH-1:0] rnum_ff, rnum_in;
   logic [rau_pkg::DEN_WIDTH-1:0]        rden_ff, rden_in;
   logic [rau_pkg::SIGN_WIDTH-1:0]       rsign_ff, rsign_in;
   logic                                 rerr_ff, rerr_in;

   rau_pkg::unit_ctl_type gcd_ctl, div_ctl;
   rau_pkg::unit_sts_type gcd_sts, div_sts;
   logic [MW-1:0]         gcd_g, div_q, div_dvd, div_dsr;

   logic accept, bad_in;

   assign accept = start && (state_ff == S_IDLE);
   assign bad_in = (req_a_den == '0) || (req_b_den == '0) ||
                   ((req_op == rau_pkg::OP_DIV) && (req_b_num == '0));

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_MA: begin
            mul_x = an_ff;
            mul_y = (op_ff == rau_pkg::OP_MUL) ? bn_ff : bd_ff;
         end
         S_MB: begin
            mul_x = bn_ff;
            mul_y = ad_ff;
         end
         default: begin
            mul_x = ad_ff;
            mul_y = (op_ff == rau_pkg::OP_DIV) ? bn_ff : bd_ff;
         end
      endcase
   end

   assign prod_in = PW'(mul_x) * PW'(mul_y);

   assign num_abs  = num_ff[SW-1] ? -num_ff : num_ff;
   assign den_abs  = den_ff[PW-1] ? -den_ff : den_ff;
   assign qn_ext   = {1'b0, qn_ff};
   assign num_sv   = neg_ff ? -signed'(qn_ext) : signed'(qn_ext);
   assign num_wide = EW'(num_sv);
   assign den_wide = EW'(div_q);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      an_in       = an_ff;
      ad_in       = ad_ff;
      bn_in       = bn_ff;
      bd_in       = bd_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      un_in       = un_ff;
      ud_in       = ud_ff;
      g_in        = g_ff;
      qn_in       = qn_ff;
      neg_in      = neg_ff;
      rnum_in     = rnum_ff;
      rden_in     = rden_ff;
      rsign_in    = rsign_ff;
      rerr_in     = rerr_ff;
      gcd_ctl.go  = 1'b0;
      div_ctl.go  = 1'b0;
      div_dvd     = un_ff;
      div_dsr     = gcd_g;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_op;
               an_in = req_a_num;
               ad_in = req_a_den;
               bn_in = req_b_num;
               bd_in = req_b_den;
               if (bad_in) begin
                  rnum_in  = '0;
                  rden_in  = rau_pkg::DEN_WIDTH'(1);
                  rsign_in = rau_pkg::SIGN_ZERO;
                  rerr_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MA;
               end
            end
         end
         S_MA: begin
            state_in = S_MB;
         end
         S_MB: begin
            num_in   = SW'(prod_ff);
            state_in = S_MC;
         end
         S_MC: begin
            if (op_ff == rau_pkg::OP_ADD) begin
               num_in = num_ff + SW'(prod_ff);
            end else if (op_ff == rau_pkg::OP_SUB) begin
               num_in = num_ff - SW'(prod_ff);
            end
            state_in = S_MD;
         end
         S_MD: begin
            den_in   = prod_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (num_ff == '0) begin
               rnum_in  = '0;
               rden_in  = rau_pkg::DEN_WIDTH'(1);
               rsign_in = rau_pkg::SIGN_ZERO;
               rerr_in  = 1'b0;
               state_in = S_OUT;
            end else begin
               un_in      = num_abs[MW-1:0];
               ud_in      = den_abs;
               neg_in     = num_ff[SW-1] ^ den_ff[PW-1];
               gcd_ctl.go = 1'b1;
               state_in   = S_GCD;
            end
         end
         S_GCD: begin
            if (gcd_sts.done) begin
               g_in       = gcd_g;
               div_ctl.go = 1'b1;
               div_dvd    = un_ff;
               div_dsr    = gcd_g;
               state_in   = S_DIVN;
            end
         end
         S_DIVN: begin
            if (div_sts.done) begin
               qn_in      = div_q;
               div_ctl.go = 1'b1;
               div_dvd    = ud_ff;
               div_dsr    = g_ff;
               state_in   = S_DIVD;
            end
         end
         S_DIVD: begin
            if (div_sts.done) begin
               rnum_in  = num_wide[rau_pkg::NUM_WIDTH-1:0];
               rden_in  = den_wide[rau_pkg::DEN_WIDTH-1:0];
               rsign_in = neg_ff ? rau_pkg::SIGN_NEG : rau_pkg::SIGN_POS;
               rerr_in  = 1'b0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      an_ff    <= an_in;
      ad_ff    <= ad_in;
      bn_ff    <= bn_in;
      bd_ff    <= bd_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      un_ff    <= un_in;
      ud_ff    <= ud_in;
      g_ff     <= g_in;
      qn_ff    <= qn_in;
      neg_ff   <= neg_in;
      rnum_ff  <= rnum_in;
      rden_ff  <= rden_in;
      rsign_ff <= rsign_in;
      rerr_ff  <= rerr_in;
   end

   rau_gcd #(
      .MAG_WIDTH (MW)
   ) u_gcd (
      .clock (clock),
      .reset (reset),
      .ctl   (gcd_ctl),
      .op_a  (num_abs[MW-1:0]),
      .op_b  (den_abs),
      .gcd   (gcd_g),
      .sts   (gcd_sts)
   );

   rau_div #(
      .MAG_WIDTH (MW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quotient (div_q),
      .sts      (div_sts)
   );

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = (state_ff == S_OUT);
   assign rsp_res_num  = rnum_ff;
   assign rsp_res_den  = rden_ff;
   assign rsp_res_sign = rsign_ff;
   assign rsp_err      = rerr_ff;

   `RAU_ASSERT_IMP(a_zero_sign_num, clock, reset,
                   rsp_valid && rsp_res_sign == rau_pkg::SIGN_ZERO, rsp_res_num == '0)
   `RAU_ASSERT_IMP(a_err_is_zero, clock, reset, rsp_valid && rsp_err,
                   rsp_res_sign == rau_pkg::SIGN_ZERO && rsp_res_den == rau_pkg::DEN_WIDTH'(1))
   `RAU_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `RAU_ASSERT_IMP(a_units_exclusive, clock, reset, gcd_sts.busy, !div_sts.busy)
   `RAU_ASSERT_NXT(a_result_idle, clock, reset, rsp_valid, !busy)

endmodule

// ----- test/rational_arithmetic_unit_core_tb.sv -----
// Self-checking testbench for rational_arithmetic_unit_core: fraction add, sub, mul, div
// with GCD reduction, checked against a built-in predictor. Depends on rau_pkg and the core.
module rational_arithmetic_unit_core_tb;

   localparam int OPW = rau_pkg::OPERAND_WIDTH_DEF;

   typedef struct {
      logic signed [rau_pkg::NUM_WIDTH-1:0] num;
      logic [rau_pkg::DEN_WIDTH-1:0]        den;
      logic [rau_pkg::SIGN_WIDTH-1:0]       sign;
      logic                                 err;
   } fraction_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic [rau_pkg::OP_WIDTH-1:0]         req_op = rau_pkg::OP_ADD;
   logic signed [OPW-1:0]                req_a_num = '0;
   logic signed [OPW-1:0]                req_a_den = '0;
   logic signed [OPW-1:0]                req_b_num = '0;
   logic signed [OPW-1:0]                req_b_den = '0;
   logic                                 rsp_valid;
   logic signed [rau_pkg::NUM_WIDTH-1:0] rsp_res_num;
   logic [rau_pkg::DEN_WIDTH-1:0]        rsp_res_den;
   logic [rau_pkg::SIGN_WIDTH-1:0]       rsp_res_sign;
   logic                                 rsp_err;

   fraction_result_type pending_fractions[$];
   int unsigned         mismatch_count = 0;

   rational_arithmetic_unit_core #(
      .OPERAND_WIDTH(OPW)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_valid    (rsp_valid),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_res_sign (rsp_res_sign),
      .rsp_err      (rsp_err)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact fraction arithmetic in 64 bits, then reduce by the Euclidean GCD.
   function automatic fraction_result_type combine_fractions(
         logic [rau_pkg::OP_WIDTH-1:0] op,
         logic signed [OPW-1:0] an, logic signed [OPW-1:0] ad,
         logic signed [OPW-1:0] bn, logic signed [OPW-1:0] bd);
      fraction_result_type res;
      longint              n;
      longint              d;
      longint unsigned     un;
      longint unsigned     ud;
      longint unsigned     x;
      longint unsigned     y;
      longint unsigned     r;
      logic                neg;
      res.num  = '0;
      res.den  = rau_pkg::DEN_WIDTH'(1);
      res.sign = rau_pkg::SIGN_ZERO;
      res.err  = 1'b0;
      if (ad == 0 || bd == 0 || (op == rau_pkg::OP_DIV && bn == 0)) begin
         res.err = 1'b1;
         return res;
      end
      case (op)
         rau_pkg::OP_ADD: begin
            n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
            d = longint'(ad) * longint'(bd);
         end
         rau_pkg::OP_SUB: begin
            n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
            d = longint'(ad) * longint'(bd);
         end
         rau_pkg::OP_MUL: begin
            n = longint'(an) * longint'(bn);
            d = longint'(ad) * longint'(bd);
         end
         default: begin
            n = longint'(an) * longint'(bd);
            d = longint'(ad) * longint'(bn);
         end
      endcase
      if (n == 0)
         return res;
      un = (n < 0) ? longint'(-n) : longint'(n);
      ud = (d < 0) ? longint'(-d) : longint'(d);
      x = un;
      y = ud;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      un = un / x;
      ud = ud / x;
      neg = (n < 0) != (d < 0);
      res.num  = neg ? rau_pkg::NUM_WIDTH'(-un) : rau_pkg::NUM_WIDTH'(un);
      res.den  = rau_pkg::DEN_WIDTH'(ud);
      res.sign = neg ? rau_pkg::SIGN_NEG : rau_pkg::SIGN_POS;
      return res;
   endfunction

   // Present one item and hold it until the core takes it; start stays high afterwards.
   task automatic send_fraction_pair(logic [rau_pkg::OP_WIDTH-1:0] op,
         logic signed [OPW-1:0] an, logic signed [OPW-1:0] ad,
         logic signed [OPW-1:0] bn, logic signed [OPW-1:0] bd);
      req_op    <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      start     <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      pending_fractions.push_back(combine_fractions(op, an, ad, bn, bd));
   endtask

   // Directed items written as plain integers.
   task automatic send_fraction_ints(logic [rau_pkg::OP_WIDTH-1:0] op,
         int an, int ad, int bn, int bd);
      send_fraction_pair(op, OPW'(an), OPW'(ad), OPW'(bn), OPW'(bd));
   endtask

   // Mostly short gaps, now and then a long one.
   task automatic idle_gap();
      int unsigned cycles;
      if ($urandom_range(0, 9) < 6)
         cycles = $urandom_range(0, 2);
      else if ($urandom_range(0, 3) != 0)
         cycles = $urandom_range(3, 12);
      else
         cycles = $urandom_range(30, 80);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic signed [OPW-1:0] random_operand();
      logic signed [OPW-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = {1'b1, {(OPW-1){1'b0}}};
               1: v = {1'b0, {(OPW-1){1'b1}}};
               2: v = '1;
               3: v = '0;
               default: v = OPW'(1);
            endcase
         end
         1, 2, 3: v = OPW'($signed($urandom_range(0, 16)) - 8);
         default: v = OPW'($urandom);
      endcase
      return v;
   endfunction

   task automatic test_basic_ops();
      send_fraction_ints(rau_pkg::OP_ADD, 1, 2, 1, 3);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_SUB, 1, 3, 1, 2);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_SUB, 3, 4, -5, 7);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_MUL, -6, 35, 14, 9);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_DIV, 4, -9, -8, 27);
      idle_gap();
      // both denominators negative: sign must end up on the numerator only
      send_fraction_ints(rau_pkg::OP_ADD, 5, -6, 7, -10);
      idle_gap();
   endtask

   task automatic test_extremes();
      send_fraction_ints(rau_pkg::OP_ADD, -32768, -32768, -32768, -32768);
      send_fraction_ints(rau_pkg::OP_SUB, -32768, 32767, 32767, -32768);
      send_fraction_ints(rau_pkg::OP_MUL, -32768, 1, -32768, 1);
      send_fraction_ints(rau_pkg::OP_MUL, 1, -32768, 1, -32768);
      send_fraction_ints(rau_pkg::OP_DIV, -32768, 1, 1, -32768);
      send_fraction_ints(rau_pkg::OP_ADD, -32768, 32767, -32768, 32766);
      send_fraction_ints(rau_pkg::OP_SUB, 32767, 1, -32768, 1);
      send_fraction_ints(rau_pkg::OP_ADD, 32767, -32768, 32767, 32767);
      idle_gap();
   endtask

   task automatic test_error_and_zero_cases();
      send_fraction_ints(rau_pkg::OP_ADD, 5, 0, 3, 4);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_MUL, 5, 3, 3, 0);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_DIV, 0, 0, 0, 0);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_DIV, 7, 3, 0, 5);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_ADD, 1, 2, -1, 2);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_SUB, 3, 4, -6, -8);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_MUL, 0, -7, 9, 11);
      idle_gap();
      send_fraction_ints(rau_pkg::OP_DIV, 0, 13, -5, 2);
      idle_gap();
   endtask

   task automatic test_random_mix();
      int unsigned                  sent;
      int unsigned                  burst;
      bit                           back_to_back;
      logic [rau_pkg::OP_WIDTH-1:0] op;
      logic signed [OPW-1:0]        an;
      logic signed [OPW-1:0]        ad;
      logic signed [OPW-1:0]        bn;
      logic signed [OPW-1:0]        bd;
      sent = 0;
      while (sent < 528) begin
         burst = $urandom_range(1, 30);
         if (burst > 528 - sent)
            burst = 528 - sent;
         back_to_back = ($urandom_range(0, 3) == 0);
         repeat (burst) begin
            op = rau_pkg::OP_WIDTH'($urandom_range(0, 3));
            an = random_operand();
            ad = random_operand();
            bn = random_operand();
            bd = random_operand();
            // keep zero denominators to a modest share
            if (ad == 0 && $urandom_range(0, 3) != 0)
               ad = OPW'(1);
            if (bd == 0 && $urandom_range(0, 3) != 0)
               bd = OPW'(-1);
            send_fraction_pair(op, an, ad, bn, bd);
            sent++;
            if (!back_to_back)
               idle_gap();
         end
      end
   endtask

   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_fractions.size() == 0) begin
            $display("%0t: unexpected result num=%0d den=%0d sign=%0d err=%0b", $time,
                     rsp_res_num, rsp_res_den, rsp_res_sign, rsp_err);
            mismatch_count++;
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_res_num !== want.num) begin
               $display("%0t: res_num expected %0d actual %0d", $time, want.num, rsp_res_num);
               mismatch_count++;
            end
            if (rsp_res_den !== want.den) begin
               $display("%0t: res_den expected %0d actual %0d", $time, want.den, rsp_res_den);
               mismatch_count++;
            end
            if (rsp_res_sign !== want.sign) begin
               $display("%0t: res_sign expected %0d actual %0d", $time, want.sign,
                        rsp_res_sign);
               mismatch_count++;
            end
            if (rsp_err !== want.err) begin
               $display("%0t: err expected %0b actual %0b", $time, want.err, rsp_err);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_extremes();
      test_error_and_zero_cases();
      test_random_mix();
      start <= 1'b0;
      while (pending_fractions.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("rational_arithmetic_unit_core_tb passed");
      else
         $display("rational_arithmetic_unit_core_tb failed");
      $finish;
   end

   initial begin
      #10000000;
      $display("rational_arithmetic_unit_core_tb failed");
      $finish;
   end

endmodule
